FILE: rtl/core/assert_macros.svh
// Assertion shorthands; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define STI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/sti_pkg.sv
package sti_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int CW   = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
    localparam int DW   = CW + 1;
    localparam int NW   = 2 * DW + 1;
    localparam int TW   = NW + DW + 2;
    localparam int HW   = (TW + 1) / 2;
    localparam int NNW  = 2 * NW + 2;
    localparam int NH   = (NNW + 1) / 2;
    localparam int EW   = 8;
    localparam int ESW  = 2 * EW;
    localparam int DDW  = 2 * TW;
    localparam int LIMW = NNW + ESW;
    localparam int CMPW = (DDW > LIMW) ? DDW : LIMW;
    localparam int RW   = TW + DW;
    localparam int AW   = 3;

    localparam logic [AW-3:0] REG_PARALLEL_EPS = '0;

    localparam logic [1:0] OUT_HIT      = 2'd0;
    localparam logic [1:0] OUT_PARALLEL = 2'd1;
    localparam logic [1:0] OUT_BEYOND   = 2'd2;
    localparam logic [1:0] OUT_OUTSIDE  = 2'd3;

endpackage

FILE: rtl/core/sti_if.sv
interface sti_req_if;
    logic        valid;
    logic        ready;
    logic [47:0] seg_start;
    logic [47:0] seg_end;
    logic [47:0] tri_a;
    logic [47:0] tri_b;
    logic [47:0] tri_c;

    modport source (output valid, seg_start, seg_end, tri_a, tri_b, tri_c, input ready);
    modport sink   (input valid, seg_start, seg_end, tri_a, tri_b, tri_c, output ready);
endinterface

interface sti_res_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic [1:0]         outcome;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;

    modport source (output valid, hit, outcome, point_x, point_y, point_z, input ready);
    modport sink   (input valid, hit, outcome, point_x, point_y, point_z, output ready);
endinterface

FILE: rtl/core/sti_div_lane.sv
module sti_div_lane (
    input  logic                   clk,
    input  logic                   en,
    input  logic [sti_pkg::RW-1:0] dividend,
    input  logic [sti_pkg::TW-1:0] divisor,
    output logic [sti_pkg::DW-1:0] quot,
    output logic                   rem_nz
);
    import sti_pkg::*;

    logic [RW-1:0] rem_reg [DW];
    logic [TW-1:0] den_reg [DW];
    logic [DW-1:0] q_reg   [DW];
    logic [RW-1:0] rem_next [DW];
    logic [DW-1:0] q_next   [DW];

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < DW; k++)
    begin : g_step
        logic [RW-1:0] rem_in;
        logic [TW-1:0] den_in;
        logic [DW-1:0] q_in;
        logic [RW-1:0] shifted;

        if (k == 0)
        begin : g_first
            assign rem_in = dividend;
            assign den_in = divisor;
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        assign shifted = RW'(den_in) << (DW - 1 - k);

        always_comb
        begin
            rem_next[k] = rem_in;
            q_next[k]   = q_in;
            if (rem_in >= shifted)
            begin
                rem_next[k]            = rem_in - shifted;
                q_next[k][DW - 1 - k]  = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_in;
                q_reg[k]   <= q_next[k];
            end
        end
    end

    assign quot   = q_reg[DW-1];
    assign rem_nz = |rem_reg[DW-1];

endmodule

FILE: rtl/core/segment_triangle_intersect.sv
// The pipeline holds 6 arithmetic stages, 17 divider stages and an output
// register between request acceptance and result valid.
// Throughput: one request per cycle; the 17-stage restoring divider lanes are
// fully pipelined, and a stall at the result side freezes every stage.
// Reset (rst_n low, asynchronous): pipeline empty, parallel_eps cleared to 0.
module segment_triangle_intersect (
    input  logic                   clk,
    input  logic                   rst_n,
    sti_req_if.sink                req,
    sti_res_if.source              res,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [sti_pkg::AW-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import sti_pkg::*;
    `include "assert_macros.svh"

    localparam int NST = 7 + DW;

    typedef struct packed {
        logic [2:0][CW-1:0] p0;
        logic [2:0]         dneg;
        logic [2:0][DW-1:0] dabs;
    } side_t;

    typedef struct packed {
        logic [1:0]         outcome;
        logic [2:0][CW-1:0] p0;
        logic [2:0]         dneg;
    } tail_t;

    function automatic logic signed [CW-1:0] coord(input logic [47:0] v, input int slot);
        coord = v[16*slot +: CW];
    endfunction

    function automatic logic signed [NW-1:0] xc(input logic signed [DW-1:0] a,
        input logic signed [DW-1:0] b, input logic signed [DW-1:0] c,
        input logic signed [DW-1:0] e);
        logic signed [NW-1:0] p;
        logic signed [NW-1:0] q;
        p  = NW'(a) * NW'(b);
        q  = NW'(c) * NW'(e);
        xc = p - q;
    endfunction

    function automatic logic signed [TW-1:0] dotp(input logic signed [NW-1:0] n0,
        input logic signed [NW-1:0] n1, input logic signed [NW-1:0] n2,
        input logic signed [DW-1:0] a0, input logic signed [DW-1:0] a1,
        input logic signed [DW-1:0] a2);
        dotp = TW'(n0) * TW'(a0) + TW'(n1) * TW'(a1) + TW'(n2) * TW'(a2);
    endfunction

    // configuration
    logic [EW-1:0]  eps_reg;
    logic [ESW-1:0] eps_sq_reg;
    logic [EW-1:0]  eps_next;
    logic           cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[AW-1:2] == REG_PARALLEL_EPS);
    assign eps_next = pwdata[EW-1:0];
    assign prdata   = (paddr[AW-1:2] == REG_PARALLEL_EPS) ? 32'(eps_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg    <= '0;
            eps_sq_reg <= '0;
        end
        else if (cfg_wr)
        begin
            eps_reg    <= eps_next;
            eps_sq_reg <= ESW'(eps_next) * ESW'(eps_next);
        end
    end

    // flow control
    logic [NST-1:0] vld_reg;
    logic           adv;

    assign adv       = !vld_reg[NST-1] || res.ready;
    assign req.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], req.valid};
    end

    // stage 1: differences
    logic signed [DW-1:0] s1_d_reg [3], s1_u_reg [3], s1_v_reg [3];
    logic signed [DW-1:0] s1_ap_reg [3], s1_bp_reg [3], s1_cp_reg [3];
    side_t                s1_side_reg;
    logic signed [DW-1:0] s1_d_next [3], s1_u_next [3], s1_v_next [3];
    logic signed [DW-1:0] s1_ap_next [3], s1_bp_next [3], s1_cp_next [3];
    side_t                s1_side_next;

    always_comb
    begin
        logic signed [DW-1:0] p0, p1, a, b, c;
        for (int i = 0; i < 3; i++)
        begin
            p0 = DW'(coord(req.seg_start, i));
            p1 = DW'(coord(req.seg_end, i));
            a  = DW'(coord(req.tri_a, i));
            b  = DW'(coord(req.tri_b, i));
            c  = DW'(coord(req.tri_c, i));
            s1_d_next[i]  = p1 - p0;
            s1_u_next[i]  = b - a;
            s1_v_next[i]  = c - a;
            s1_ap_next[i] = a - p0;
            s1_bp_next[i] = b - p0;
            s1_cp_next[i] = c - p0;
            s1_side_next.p0[i]   = coord(req.seg_start, i);
            s1_side_next.dneg[i] = s1_d_next[i] < 0;
            s1_side_next.dabs[i] = s1_d_next[i] < 0 ? -s1_d_next[i] : s1_d_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_d_reg    <= s1_d_next;
            s1_u_reg    <= s1_u_next;
            s1_v_reg    <= s1_v_next;
            s1_ap_reg   <= s1_ap_next;
            s1_bp_reg   <= s1_bp_next;
            s1_cp_reg   <= s1_cp_next;
            s1_side_reg <= s1_side_next;
        end
    end

    // stage 2: cross products
    logic signed [NW-1:0] s2_n_reg [3], s2_cb_reg [3], s2_ca_reg [3], s2_cab_reg [3];
    logic signed [DW-1:0] s2_d_reg [3], s2_ap_reg [3];
    side_t                s2_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s2_n_reg[i]   <= xc(s1_u_reg[(i+1)%3], s1_v_reg[(i+2)%3],
                                    s1_u_reg[(i+2)%3], s1_v_reg[(i+1)%3]);
                s2_cb_reg[i]  <= xc(s1_bp_reg[(i+1)%3], s1_cp_reg[(i+2)%3],
                                    s1_bp_reg[(i+2)%3], s1_cp_reg[(i+1)%3]);
                s2_ca_reg[i]  <= xc(s1_cp_reg[(i+1)%3], s1_ap_reg[(i+2)%3],
                                    s1_cp_reg[(i+2)%3], s1_ap_reg[(i+1)%3]);
                s2_cab_reg[i] <= xc(s1_ap_reg[(i+1)%3], s1_bp_reg[(i+2)%3],
                                    s1_ap_reg[(i+2)%3], s1_bp_reg[(i+1)%3]);
            end
            s2_d_reg    <= s1_d_reg;
            s2_ap_reg   <= s1_ap_reg;
            s2_side_reg <= s1_side_reg;
        end
    end

    // stage 3: dot products, normal squares
    logic signed [TW-1:0] s3_num_reg, s3_den_reg, s3_va_reg, s3_vb_reg, s3_vc_reg;
    logic [2*NW-1:0]      s3_nsq_reg [3];
    logic                 s3_degen_reg;
    side_t                s3_side_reg;
    logic [2*NW-1:0]      s3_nsq_next [3];

    always_comb
    begin
        logic [NW-1:0] nm;
        for (int i = 0; i < 3; i++)
        begin
            nm             = s2_n_reg[i] < 0 ? NW'(-s2_n_reg[i]) : NW'(s2_n_reg[i]);
            s3_nsq_next[i] = (2*NW)'(nm) * (2*NW)'(nm);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_num_reg   <= dotp(s2_n_reg[0], s2_n_reg[1], s2_n_reg[2],
                                 s2_ap_reg[0], s2_ap_reg[1], s2_ap_reg[2]);
            s3_den_reg   <= dotp(s2_n_reg[0], s2_n_reg[1], s2_n_reg[2],
                                 s2_d_reg[0], s2_d_reg[1], s2_d_reg[2]);
            s3_va_reg    <= dotp(s2_cb_reg[0], s2_cb_reg[1], s2_cb_reg[2],
                                 s2_d_reg[0], s2_d_reg[1], s2_d_reg[2]);
            s3_vb_reg    <= dotp(s2_ca_reg[0], s2_ca_reg[1], s2_ca_reg[2],
                                 s2_d_reg[0], s2_d_reg[1], s2_d_reg[2]);
            s3_vc_reg    <= dotp(s2_cab_reg[0], s2_cab_reg[1], s2_cab_reg[2],
                                 s2_d_reg[0], s2_d_reg[1], s2_d_reg[2]);
            s3_nsq_reg   <= s3_nsq_next;
            s3_degen_reg <= (s2_n_reg[0] == '0) && (s2_n_reg[1] == '0)
                            && (s2_n_reg[2] == '0);
            s3_side_reg  <= s2_side_reg;
        end
    end

    // stage 4: sign normalise, partial products of den^2, |n|^2
    logic signed [TW-1:0]  s4_num_reg, s4_va_reg, s4_vb_reg, s4_vc_reg;
    logic [TW-1:0]         s4_dmag_reg;
    logic                  s4_dzero_reg, s4_degen_reg;
    logic [2*HW-1:0]       s4_pll_reg;
    logic [TW-1:0]         s4_plh_reg;
    logic [2*(TW-HW)-1:0]  s4_phh_reg;
    logic [NNW-1:0]        s4_nn_reg;
    side_t                 s4_side_reg;
    logic [TW-1:0]         s4_dmag_next;
    logic                  s4_neg;

    assign s4_neg       = s3_den_reg < 0;
    assign s4_dmag_next = s4_neg ? TW'(-s3_den_reg) : TW'(s3_den_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_num_reg   <= s4_neg ? -s3_num_reg : s3_num_reg;
            s4_va_reg    <= s4_neg ? -s3_va_reg : s3_va_reg;
            s4_vb_reg    <= s4_neg ? -s3_vb_reg : s3_vb_reg;
            s4_vc_reg    <= s4_neg ? -s3_vc_reg : s3_vc_reg;
            s4_dmag_reg  <= s4_dmag_next;
            s4_dzero_reg <= s3_den_reg == '0;
            s4_degen_reg <= s3_degen_reg;
            s4_pll_reg   <= (2*HW)'(s4_dmag_next[HW-1:0]) * (2*HW)'(s4_dmag_next[HW-1:0]);
            s4_plh_reg   <= TW'(s4_dmag_next[HW-1:0]) * TW'(s4_dmag_next[TW-1:HW]);
            s4_phh_reg   <= (2*(TW-HW))'(s4_dmag_next[TW-1:HW])
                            * (2*(TW-HW))'(s4_dmag_next[TW-1:HW]);
            s4_nn_reg    <= NNW'(s3_nsq_reg[0]) + NNW'(s3_nsq_reg[1]) + NNW'(s3_nsq_reg[2]);
            s4_side_reg  <= s3_side_reg;
        end
    end

    // stage 5: den^2, eps^2 * |n|^2 partials
    logic signed [TW-1:0]   s5_num_reg, s5_va_reg, s5_vb_reg, s5_vc_reg;
    logic [TW-1:0]          s5_dmag_reg;
    logic                   s5_dzero_reg, s5_degen_reg;
    logic [DDW-1:0]         s5_dd_reg;
    logic [NH+ESW-1:0]      s5_limlo_reg;
    logic [NNW-NH+ESW-1:0]  s5_limhi_reg;
    side_t                  s5_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_num_reg   <= s4_num_reg;
            s5_va_reg    <= s4_va_reg;
            s5_vb_reg    <= s4_vb_reg;
            s5_vc_reg    <= s4_vc_reg;
            s5_dmag_reg  <= s4_dmag_reg;
            s5_dzero_reg <= s4_dzero_reg;
            s5_degen_reg <= s4_degen_reg;
            s5_dd_reg    <= (DDW'(s4_phh_reg) << (2*HW)) + (DDW'(s4_plh_reg) << (HW+1))
                            + DDW'(s4_pll_reg);
            s5_limlo_reg <= (NH+ESW)'(s4_nn_reg[NH-1:0]) * (NH+ESW)'(eps_sq_reg);
            s5_limhi_reg <= (NNW-NH+ESW)'(s4_nn_reg[NNW-1:NH]) * (NNW-NH+ESW)'(eps_sq_reg);
            s5_side_reg  <= s4_side_reg;
        end
    end

    // stage 6: classify, numerators for the crossing point
    logic [CMPW-1:0] s6_lim;
    logic            s6_par;
    logic [1:0]      s6_outcome;
    logic [RW-1:0]   s6_prod_reg [3];
    logic [TW-1:0]   s6_dmag_reg;
    tail_t           s6_tail_reg;

    assign s6_lim = (CMPW'(s5_limhi_reg) << NH) + CMPW'(s5_limlo_reg);
    assign s6_par = s5_dzero_reg || (CMPW'(s5_dd_reg) < s6_lim);

    always_comb
    begin
        if (s5_degen_reg || s6_par)
            s6_outcome = OUT_PARALLEL;
        else if (s5_num_reg < 0 || s5_num_reg > $signed(s5_dmag_reg))
            s6_outcome = OUT_BEYOND;
        else if (s5_va_reg < 0 || s5_vb_reg < 0 || s5_vc_reg < 0)
            s6_outcome = OUT_OUTSIDE;
        else
            s6_outcome = OUT_HIT;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                s6_prod_reg[i] <= RW'(s5_num_reg) * RW'(s5_side_reg.dabs[i]);
            s6_dmag_reg         <= s5_dmag_reg;
            s6_tail_reg.outcome <= s6_outcome;
            s6_tail_reg.p0      <= s5_side_reg.p0;
            s6_tail_reg.dneg    <= s5_side_reg.dneg;
        end
    end

    // divider lanes
    logic [DW-1:0] quot [3];
    logic [2:0]    rem_nz;
    tail_t         tail_reg [DW];

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        sti_div_lane u_div (
            .clk      (clk),
            .en       (adv),
            .dividend (s6_prod_reg[i]),
            .divisor  (s6_dmag_reg),
            .quot     (quot[i]),
            .rem_nz   (rem_nz[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tail_reg[0] <= s6_tail_reg;
            for (int k = 1; k < DW; k++)
                tail_reg[k] <= tail_reg[k-1];
        end
    end

    // output register
    logic                hit_reg;
    logic [1:0]          outcome_reg;
    logic signed [15:0]  pt_reg [3];
    logic signed [15:0]  pt_next [3];
    logic                hit_next;

    assign hit_next = tail_reg[DW-1].outcome == OUT_HIT;

    // negative direction rounds the magnitude up so the step is floored
    always_comb
    begin
        logic [DW:0]        mq;
        logic signed [DW:0] step;
        logic signed [15:0] base;
        for (int i = 0; i < 3; i++)
        begin
            mq   = {1'b0, quot[i]}
                   + (DW+1)'(rem_nz[i] && tail_reg[DW-1].dneg[i]);
            step = tail_reg[DW-1].dneg[i] ? -$signed(mq) : $signed(mq);
            base = 16'($signed(tail_reg[DW-1].p0[i]));
            pt_next[i] = hit_next ? base + 16'(step) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg     <= hit_next;
            outcome_reg <= tail_reg[DW-1].outcome;
            pt_reg      <= pt_next;
        end
    end

    assign res.valid   = vld_reg[NST-1];
    assign res.hit     = hit_reg;
    assign res.outcome = outcome_reg;
    assign res.point_x = pt_reg[0];
    assign res.point_y = pt_reg[1];
    assign res.point_z = pt_reg[2];

    `STI_ASSERT_NOW(a_ready_follows_out, 1'b1, req.ready == (!res.valid || res.ready), "ready mismatch")
    `STI_ASSERT_NOW(a_hit_code, res.valid && res.hit, res.outcome == OUT_HIT, "hit with miss code")
    `STI_ASSERT_NOW(a_miss_zero, res.valid && !res.hit, res.outcome != OUT_HIT && res.point_x == '0 && res.point_y == '0 && res.point_z == '0, "miss not cleared")
    `STI_ASSERT_NEXT(a_stall_hold, !adv, $stable(vld_reg), "pipeline moved in stall")

endmodule

FILE: tb/segment_triangle_intersect_test.sv
`timescale 1ns / 1ps

module segment_triangle_intersect_test;
    import sti_pkg::*;

    typedef longint vec3_t [3];

    typedef struct {
        logic        hit;
        logic [1:0]  outcome;
        logic [15:0] point_x;
        logic [15:0] point_y;
        logic [15:0] point_z;
    } crossing_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    sti_req_if req ();
    sti_res_if res ();

    segment_triangle_intersect i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req.sink),
        .res     (res.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    crossing_t crossing_q [$];
    logic [7:0] eps_model;
    logic steady;
    int errors;
    int quiet_cycles;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic vec3_t unpack_point(logic [47:0] w);
        vec3_t p;
        for (int i = 0; i < 3; i++)
            p[i] = longint'($signed(w[16*i +: 16]));
        return p;
    endfunction

    function automatic vec3_t cross_of(vec3_t x, vec3_t y);
        vec3_t o;
        o[0] = x[1] * y[2] - x[2] * y[1];
        o[1] = x[2] * y[0] - x[0] * y[2];
        o[2] = x[0] * y[1] - x[1] * y[0];
        return o;
    endfunction

    function automatic longint dot_of(vec3_t x, vec3_t y);
        return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
    endfunction

    function automatic logic [127:0] square_of(longint x);
        logic [127:0] m;
        m = (x < 0) ? 128'(-x) : 128'(x);
        return m * m;
    endfunction

    function automatic crossing_t predict_crossing(logic [47:0] s0, logic [47:0] s1,
                                                   logic [47:0] a, logic [47:0] b,
                                                   logic [47:0] c, logic [7:0] eps);
        vec3_t p0, pa, pb, pc, d, u, v, ap, bp, cp, n;
        longint num, den, va, vb, vc, step, mag_d;
        logic [127:0] lim, q, r;
        crossing_t x;
        p0 = unpack_point(s0);
        pa = unpack_point(a);
        pb = unpack_point(b);
        pc = unpack_point(c);
        d = unpack_point(s1);
        for (int i = 0; i < 3; i++)
        begin
            d[i] = d[i] - p0[i];
            u[i] = pb[i] - pa[i];
            v[i] = pc[i] - pa[i];
            ap[i] = pa[i] - p0[i];
            bp[i] = pb[i] - p0[i];
            cp[i] = pc[i] - p0[i];
        end
        x = '{1'b0, OUT_PARALLEL, 16'd0, 16'd0, 16'd0};
        n = cross_of(u, v);
        num = dot_of(n, ap);
        den = dot_of(n, d);
        if (n[0] == 0 && n[1] == 0 && n[2] == 0)
            return x;
        lim = (square_of(n[0]) + square_of(n[1]) + square_of(n[2])) * 128'(eps) * 128'(eps);
        if (den == 0 || square_of(den) < lim)
            return x;
        va = dot_of(d, cross_of(bp, cp));
        vb = dot_of(d, cross_of(cp, ap));
        vc = dot_of(d, cross_of(ap, bp));
        if (den < 0)
        begin
            den = -den;
            num = -num;
            va = -va;
            vb = -vb;
            vc = -vc;
        end
        if (num < 0 || num > den)
        begin
            x.outcome = OUT_BEYOND;
            return x;
        end
        if (va < 0 || vb < 0 || vc < 0)
        begin
            x.outcome = OUT_OUTSIDE;
            return x;
        end
        x.hit = 1'b1;
        x.outcome = OUT_HIT;
        for (int i = 0; i < 3; i++)
        begin
            mag_d = (d[i] < 0) ? -d[i] : d[i];
            q = (128'(num) * 128'(mag_d)) / 128'(den);
            r = (128'(num) * 128'(mag_d)) % 128'(den);
            step = (d[i] < 0) ? -(longint'(q) + ((r != 0) ? 1 : 0)) : longint'(q);
            case (i)
                0: x.point_x = 16'(p0[i] + step);
                1: x.point_y = 16'(p0[i] + step);
                default: x.point_z = 16'(p0[i] + step);
            endcase
        end
        return x;
    endfunction

    function automatic logic [47:0] pt(int px, int py, int pz);
        return {16'(pz), 16'(py), 16'(px)};
    endfunction

    // record each accepted request with the prediction at the current tolerance
    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
            crossing_q.insert(crossing_q.size(),
                              predict_crossing(req.seg_start, req.seg_end, req.tri_a,
                                               req.tri_b, req.tri_c, eps_model));
    end

    always @(posedge clk)
    begin
        crossing_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (crossing_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result hit=%0b outcome=%0d", $time,
                         res.hit, res.outcome);
            end
            else
            begin
                want = crossing_q.pop_front();
                if (res.hit !== want.hit || res.outcome !== want.outcome
                    || res.point_x !== want.point_x || res.point_y !== want.point_y
                    || res.point_z !== want.point_z)
                begin
                    errors++;
                    $display("%0t: expected hit=%0b outcome=%0d point=(%0d,%0d,%0d) actual hit=%0b outcome=%0d point=(%0d,%0d,%0d)",
                             $time, want.hit, want.outcome, $signed(want.point_x),
                             $signed(want.point_y), $signed(want.point_z), res.hit,
                             res.outcome, res.point_x, res.point_y, res.point_z);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            res.ready <= steady ? 1'b1 : ($urandom_range(99) >= 11);
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (res.valid && res.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_request(logic [47:0] s0, logic [47:0] s1, logic [47:0] a,
                                logic [47:0] b, logic [47:0] c);
        while (!steady && $urandom_range(99) < 11)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.seg_start <= s0;
        req.seg_end <= s1;
        req.tri_a <= a;
        req.tri_b <= b;
        req.tri_c <= c;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        @(posedge clk);
        while (crossing_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_eps(logic [7:0] value);
        drain_results();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= AW'(REG_PARALLEL_EPS) << 2;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        eps_model = value;
        @(posedge clk);
    endtask

    function automatic int rand_signed(int span);
        return $urandom_range(2 * span) - span;
    endfunction

    // random fields if kind < 15, else a segment to a point near the inside of a triangle, reaching it if kind >= 30
    task automatic send_random_request(int kind);
        int span, w1, w2, w3, k0, k1;
        int a [3], b [3], c [3], p [3], dir [3];
        if (kind < 15)
        begin
            send_request(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                         48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                         48'({$urandom, $urandom}));
            return;
        end
        case ($urandom_range(2))
            0: span = 60;
            1: span = 1000;
            default: span = 8000;
        endcase
        w1 = $urandom_range(100);
        w2 = $urandom_range(100);
        w3 = $urandom_range(100) + 1;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = rand_signed(span);
            b[i] = rand_signed(span);
            c[i] = rand_signed(span);
            p[i] = (a[i] * w1 + b[i] * w2 + c[i] * w3) / (w1 + w2 + w3);
            dir[i] = rand_signed(span);
        end
        k0 = $urandom_range(100);
        k1 = (kind < 30) ? -$urandom_range(100) : $urandom_range(100);
        send_request(pt(p[0] - dir[0] * k0 / 100, p[1] - dir[1] * k0 / 100,
                        p[2] - dir[2] * k0 / 100),
                     pt(p[0] + dir[0] * k1 / 100, p[1] + dir[1] * k1 / 100,
                        p[2] + dir[2] * k1 / 100),
                     pt(a[0], a[1], a[2]), pt(b[0], b[1], b[2]), pt(c[0], c[1], c[2]));
    endtask

    task automatic test_directed();
        logic [47:0] ta, tb, tc;
        ta = pt(0, 0, 0);
        tb = pt(100, 0, 0);
        tc = pt(0, 100, 0);
        send_request(pt(10, 10, -50), pt(10, 10, 50), ta, tb, tc);
        send_request(pt(33, 17, 50), pt(10, 10, -51), ta, tb, tc);
        send_request(pt(10, 10, 5), pt(10, 10, 50), ta, tb, tc);
        send_request(pt(200, 200, -5), pt(200, 200, 5), ta, tb, tc);
        send_request(pt(50, 0, -5), pt(50, 0, 5), ta, tb, tc);
        send_request(pt(0, 0, -5), pt(0, 0, 5), ta, tb, tc);
        send_request(pt(50, 50, -7), pt(50, 50, 7), ta, tb, tc);
        send_request(pt(10, 10, 0), pt(10, 10, 9), ta, tb, tc);
        send_request(pt(10, 10, -9), pt(10, 10, 0), tc, tb, ta);
        send_request(pt(5, 5, 5), pt(5, 5, 5), ta, tb, tc);
        send_request(pt(-10, 5, 3), pt(90, 5, 3), ta, tb, tc);
        send_request(pt(1, 1, -1), pt(1, 1, 1), ta, ta, ta);
        send_request(pt(1, 1, -1), pt(1, 1, 1), ta, tb, pt(300, 0, 0));
        send_request(pt(-1000, 3, -1), pt(1000, 3, 1), ta, tb, tc);
        send_request(pt(0, 0, -32768), pt(0, 0, 32767), pt(-32768, -32768, 0),
                     pt(32767, -32768, 0), pt(-32768, 32767, 0));
        send_request(pt(-32768, -32768, 32767), pt(-32767, -32767, -32768),
                     pt(-32768, -32768, 0), pt(32767, -32768, 0), pt(-32768, 32767, 0));
        send_request(pt(32767, 32767, -32768), pt(32767, 32767, 32767),
                     pt(32767, 32767, 0), pt(-32768, 32767, 0), pt(32767, -32768, 0));
        send_request('1, '0, '1, '0, {48{1'b1}} >> 1);
        send_request('0, '1, '0, 48'h7fff_8000_7fff, 48'h8000_7fff_8000);
        send_request({3{16'h5555}}, {3{16'haaaa}}, {3{16'h8001}}, pt(0, 32767, -1),
                     pt(-32768, 1, 32767));
    endtask

    task automatic test_tolerance_settings();
        logic [7:0] settings [4];
        settings = '{8'd255, 8'd1, 8'($urandom_range(2, 254)), 8'd0};
        foreach (settings[k])
        begin
            write_eps(settings[k]);
            send_request(pt(-1000, 3, -1), pt(1000, 3, 1), pt(0, 0, 0), pt(100, 0, 0),
                         pt(0, 100, 0));
            send_request(pt(-20, 20, -1), pt(60, 20, 1), pt(0, 0, 0), pt(100, 0, 0),
                         pt(0, 100, 0));
            repeat (30) send_random_request($urandom_range(99));
        end
    endtask

    task automatic test_random();
        for (int k = 0; k < 580; k++)
        begin
            steady = (k >= 200 && k < 320);
            send_random_request($urandom_range(99));
        end
        steady = 1'b0;
    endtask

    task automatic test_pause_until_empty();
        repeat (10) send_random_request($urandom_range(99));
        req.valid <= 1'b0;
        @(posedge clk);
        while (crossing_q.size() != 0)
            @(posedge clk);
        repeat (10) send_random_request($urandom_range(99));
    endtask

    initial
    begin
        errors = 0;
        steady = 1'b0;
        eps_model = 8'd0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req.valid = 1'b0;
        req.seg_start = '0;
        req.seg_end = '0;
        req.tri_a = '0;
        req.tri_b = '0;
        req.tri_c = '0;
        res.ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_tolerance_settings();
        test_random();
        test_pause_until_empty();
        drain_results();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
